/* src/tvc_pkg.sv */
// Shared types, widths and codes for the toroidal Voronoi cell lookup.
package tvc_pkg;

  // Default geometry of the map and the center table.
  localparam int MAP_WIDTH_DEF   = 64;
  localparam int MAX_CENTERS_DEF = 256;

  // Fixed field widths of the request, result and configuration ports, and of the divider counter.
  localparam int CMD_W       = 2;
  localparam int POS_W       = 31;
  localparam int SW_W        = 16;
  localparam int IDX_OUT_W   = 8;
  localparam int COORD_OUT_W = 6;
  localparam int CNT_W       = $clog2(POS_W);

  // Reset value of the scaled width register.
  localparam logic [SW_W-1:0] SW_RESET = SW_W'(64);

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APP_X,
    ST_APP_Y,
    ST_Q_MOD_X,
    ST_Q_SCL_X,
    ST_Q_MOD_Y,
    ST_Q_SCL_Y,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Operation handed to the shared divider.
  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] dividend;
    logic [SW_W-1:0]  divisor;
  } div_req_t;

  // Result returned by the shared divider.
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
    logic [SW_W-1:0]  rem;
  } div_rsp_t;

endpackage

/* src/tvc_req_if.sv */
// Request channel: command and position with a valid/ready handshake.
interface tvc_req_if;
  logic                      valid;
  logic                      ready;
  logic [tvc_pkg::CMD_W-1:0] command;
  logic [tvc_pkg::POS_W-1:0] pos_x;
  logic [tvc_pkg::POS_W-1:0] pos_y;

  modport source (output valid, command, pos_x, pos_y, input ready);
  modport sink   (input valid, command, pos_x, pos_y, output ready);
endinterface

/* src/tvc_rsp_if.sv */
// Result channel: nearest center of a query with a valid/ready handshake.
interface tvc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [tvc_pkg::IDX_OUT_W-1:0]   cell_index;
  logic [tvc_pkg::COORD_OUT_W-1:0] center_x;
  logic [tvc_pkg::COORD_OUT_W-1:0] center_y;

  modport source (output valid, found, cell_index, center_x, center_y, input ready);
  modport sink   (input valid, found, cell_index, center_x, center_y, output ready);
endinterface

/* src/toroidal_voronoi_cell_lookup.sv */
// Top level of the toroidal Voronoi cell lookup: sequencer, center table and scan.
//
//   Port       Dir   Protocol      Contents
//   in_chan    in    valid/ready   command, pos_x, pos_y
//   out_chan   out   valid/ready   found, cell_index, center_x, center_y (queries only)
//   cfg_*      in    write enable  scaled_width
//
// A request is taken only while the sequencer is idle. Clear and unused commands
// never leave the idle state. An append writes the table directly on a power-of-two
// map, where the modulo by MAP_WIDTH is a mask, and takes two divider passes on any
// other map. For a query the shared bit-serial divider does the four reductions,
// then the table memory is read one center per cycle. Reset empties the table and
// sets scaled_width to 64; no clearing pass is run. A finished result waits in the
// output register while the next request is taken; a query whose predecessor is
// still unclaimed waits.
module toroidal_voronoi_cell_lookup #(
  parameter int MAP_WIDTH   = tvc_pkg::MAP_WIDTH_DEF,
  parameter int MAX_CENTERS = tvc_pkg::MAX_CENTERS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  tvc_req_if.sink                  in_chan,
  tvc_rsp_if.source                out_chan,
  input  logic                     cfg_we,
  input  logic [tvc_pkg::SW_W-1:0] cfg_wdata
);

  localparam int CW   = $clog2(MAP_WIDTH);
  localparam int IW   = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int NW   = $clog2(MAX_CENTERS + 1);
  localparam int DW   = 2 * CW + 1;
  localparam int POSW = tvc_pkg::POS_W;
  localparam int SWW  = tvc_pkg::SW_W;
  localparam bit MAP_POW2 = ((MAP_WIDTH & (MAP_WIDTH - 1)) == 0);

  tvc_pkg::state_t   state_r, state_nxt;
  tvc_pkg::div_req_t div_req;
  tvc_pkg::div_rsp_t div_rsp;

  logic [SWW-1:0]  sw_r;
  logic [SWW-1:0]  sw_eff;
  logic [POSW-1:0] pos_y_r;
  logic [CW-1:0]   cx_r;
  logic [CW-1:0]   rx_r;
  logic [CW-1:0]   ry_r;
  logic [NW-1:0]   count_r, count_nxt;
  logic [NW-1:0]   scan_idx_r;
  logic            found_r;
  logic [POSW-1:0] scale_prod;

  logic            mem_we;
  logic            mem_re;
  logic [2*CW-1:0] mem_wdata;
  logic [2*CW-1:0] mem_rdata;

  logic            rd_vld_r;
  logic [IW-1:0]   idx1_r;
  logic            d_vld_r;
  logic [DW-1:0]   d_r;
  logic [IW-1:0]   idx2_r;
  logic [CW-1:0]   cx2_r;
  logic [CW-1:0]   cy2_r;
  logic [DW-1:0]   best_d_r;
  logic [IW-1:0]   best_idx_r;
  logic [CW-1:0]   best_x_r;
  logic [CW-1:0]   best_y_r;

  logic [CW-1:0]   dist_x;
  logic [CW-1:0]   dist_y;
  logic [DW-1:0]   d_sum;

  logic                        out_valid_r;
  logic                        out_found_r;
  logic [tvc_pkg::IDX_OUT_W-1:0]   out_idx_r;
  logic [tvc_pkg::COORD_OUT_W-1:0] out_x_r;
  logic [tvc_pkg::COORD_OUT_W-1:0] out_y_r;
  logic                        load_out;
  logic [IW+tvc_pkg::IDX_OUT_W-1:0]   idx_ext;
  logic [CW+tvc_pkg::COORD_OUT_W-1:0] x_ext;
  logic [CW+tvc_pkg::COORD_OUT_W-1:0] y_ext;

  logic in_acc;
  logic scan_drained;

  // Wrapped distance along one axis of the map.
  function automatic logic [CW-1:0] wrap_dist(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW-1:0] d;
    logic [CW:0]   e;
    d = (a > b) ? (a - b) : (b - a);
    e = (CW+1)'(MAP_WIDTH) - {1'b0, d};
    return (e < {1'b0, d}) ? e[CW-1:0] : d;
  endfunction

  // Configuration register; zero behaves as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= tvc_pkg::SW_RESET;
    end else if (cfg_we) begin
      sw_r <= cfg_wdata;
    end
  end

  assign sw_eff = (sw_r == '0) ? SWW'(1) : sw_r;

  // Map offset times map width, the dividend of the scaling division.
  assign scale_prod = POSW'(div_rsp.rem) * POSW'(MAP_WIDTH);

  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == tvc_pkg::ST_IDLE);
  assign scan_drained  = (scan_idx_r == count_r) && !rd_vld_r && !d_vld_r;
  assign load_out      = (state_r == tvc_pkg::ST_DONE) && (!out_valid_r || out_chan.ready);

  // Sequencer: next state, divider requests and table writes.
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    div_req.start    = 1'b0;
    div_req.dividend = in_chan.pos_x;
    div_req.divisor  = SWW'(MAP_WIDTH);
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    unique case (state_r)
      tvc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_chan.command)
            tvc_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            tvc_pkg::CMD_APPEND: begin
              if (count_r < NW'(MAX_CENTERS)) begin
                if (MAP_POW2) begin
                  mem_we    = 1'b1;
                  count_nxt = count_r + 1'b1;
                end else begin
                  div_req.start = 1'b1;
                  state_nxt     = tvc_pkg::ST_APP_X;
                end
              end
            end
            tvc_pkg::CMD_QUERY: begin
              if (count_r == '0) begin
                state_nxt = tvc_pkg::ST_DONE;
              end else begin
                div_req.start   = 1'b1;
                div_req.divisor = sw_eff;
                state_nxt       = tvc_pkg::ST_Q_MOD_X;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tvc_pkg::ST_APP_X: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = pos_y_r;
          state_nxt        = tvc_pkg::ST_APP_Y;
        end
      end
      tvc_pkg::ST_APP_Y: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = tvc_pkg::ST_IDLE;
        end
      end
      tvc_pkg::ST_Q_MOD_X: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = scale_prod;
          div_req.divisor  = sw_eff;
          state_nxt        = tvc_pkg::ST_Q_SCL_X;
        end
      end
      tvc_pkg::ST_Q_SCL_X: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = pos_y_r;
          div_req.divisor  = sw_eff;
          state_nxt        = tvc_pkg::ST_Q_MOD_Y;
        end
      end
      tvc_pkg::ST_Q_MOD_Y: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = scale_prod;
          div_req.divisor  = sw_eff;
          state_nxt        = tvc_pkg::ST_Q_SCL_Y;
        end
      end
      tvc_pkg::ST_Q_SCL_Y: begin
        if (div_rsp.done) begin
          state_nxt = tvc_pkg::ST_SCAN;
        end
      end
      tvc_pkg::ST_SCAN: begin
        mem_re = (scan_idx_r < count_r);
        if (scan_drained) begin
          state_nxt = tvc_pkg::ST_DONE;
        end
      end
      tvc_pkg::ST_DONE: begin
        if (load_out) begin
          state_nxt = tvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tvc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tvc_pkg::ST_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
      d_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= mem_re;
      d_vld_r  <= rd_vld_r;
    end
  end

  // Request capture and reduced coordinates.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_y_r <= in_chan.pos_y;
      found_r <= (count_r != '0);
    end
    if (state_r == tvc_pkg::ST_APP_X && div_rsp.done) begin
      cx_r <= div_rsp.rem[CW-1:0];
    end
    if (state_r == tvc_pkg::ST_Q_SCL_X && div_rsp.done) begin
      rx_r <= div_rsp.quot[CW-1:0];
    end
    if (state_r == tvc_pkg::ST_Q_SCL_Y && div_rsp.done) begin
      ry_r <= div_rsp.quot[CW-1:0];
    end
  end

  // Scan address counter, restarted when the query coordinates are ready.
  always_ff @(posedge clk) begin
    if (state_r == tvc_pkg::ST_Q_SCL_Y) begin
      scan_idx_r <= '0;
    end else if (mem_re) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  // Shared divider for the modulo and scaling steps.
  tvc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Table write data: masked request coordinates when idle, divider remainders otherwise.
  assign mem_wdata = (state_r == tvc_pkg::ST_IDLE) ?
                     {in_chan.pos_x[CW-1:0], in_chan.pos_y[CW-1:0]} :
                     {cx_r, div_rsp.rem[CW-1:0]};

  // Center table; writes and scan reads never share a cycle.
  tvc_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_CENTERS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[IW-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_idx_r[IW-1:0]),
    .rdata (mem_rdata)
  );

  // Squared wrapped distance of the center just read.
  always_comb begin
    dist_x = wrap_dist(mem_rdata[2*CW-1:CW], rx_r);
    dist_y = wrap_dist(mem_rdata[CW-1:0], ry_r);
    d_sum  = DW'(dist_x) * DW'(dist_x) + DW'(dist_y) * DW'(dist_y);
  end

  // Distance stage and running minimum; the first center is always taken, and on a tie the earlier center wins.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      idx1_r <= scan_idx_r[IW-1:0];
    end
    if (rd_vld_r) begin
      d_r    <= d_sum;
      idx2_r <= idx1_r;
      cx2_r  <= mem_rdata[2*CW-1:CW];
      cy2_r  <= mem_rdata[CW-1:0];
    end
    if (d_vld_r && (idx2_r == '0 || d_r < best_d_r)) begin
      best_d_r   <= d_r;
      best_idx_r <= idx2_r;
      best_x_r   <= cx2_r;
      best_y_r   <= cy2_r;
    end
  end

  // Result fields cut to their port widths.
  assign idx_ext = {{tvc_pkg::IDX_OUT_W{1'b0}}, best_idx_r};
  assign x_ext   = {{tvc_pkg::COORD_OUT_W{1'b0}}, best_x_r};
  assign y_ext   = {{tvc_pkg::COORD_OUT_W{1'b0}}, best_y_r};

  // Output register; it holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= found_r;
      out_idx_r   <= found_r ? idx_ext[tvc_pkg::IDX_OUT_W-1:0] : '0;
      out_x_r     <= found_r ? x_ext[tvc_pkg::COORD_OUT_W-1:0] : '0;
      out_y_r     <= found_r ? y_ext[tvc_pkg::COORD_OUT_W-1:0] : '0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.found      = out_found_r;
  assign out_chan.cell_index = out_idx_r;
  assign out_chan.center_x   = out_x_r;
  assign out_chan.center_y   = out_y_r;

endmodule

/* src/tvc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tvc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tvc_div.sv */
// Restoring divider, one quotient bit per cycle, for 31-bit by 16-bit operands.
module tvc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tvc_pkg::div_req_t req,
  output tvc_pkg::div_rsp_t rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [tvc_pkg::CNT_W-1:0]     cnt_r;
  logic [tvc_pkg::POS_W-1:0]     quo_r;
  logic [tvc_pkg::SW_W-1:0]      rem_r;
  logic [tvc_pkg::SW_W-1:0]      dvs_r;
  logic [tvc_pkg::SW_W:0]        trial;
  logic                          fits;
  logic [tvc_pkg::SW_W:0]        diff;
  logic [tvc_pkg::SW_W-1:0]      rem_nxt;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    trial   = {rem_r, quo_r[tvc_pkg::POS_W-1]};
    fits    = trial >= {1'b0, dvs_r};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = fits ? diff[tvc_pkg::SW_W-1:0] : trial[tvc_pkg::SW_W-1:0];
  end

  // Control: busy while bits remain, a one-cycle done pulse at the end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == tvc_pkg::CNT_W'(tvc_pkg::POS_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      quo_r <= {quo_r[tvc_pkg::POS_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule
